// File: hdl/sliding_window_bucket_ring_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bucket ring top level
// Implication helpers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_BUCKET_RING_TOP_ASSERT_SVH
`define SLIDING_WINDOW_BUCKET_RING_TOP_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define SWBR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define SWBR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/swbr_pkg.sv
// ----------------------------------------------------------------------------
// swbr_pkg
// Types and fixed constants of the sliding-window bucket ring.
// ----------------------------------------------------------------------------
package swbr_pkg;

    // fixed field widths
    localparam int BEGIN_W    = 47;
    localparam int LEN_W      = 16;
    localparam int SLOTS_W    = 5;
    localparam int WIN_W      = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;
    localparam int STATUS_W   = 3;
    localparam int IDX_OUT_W  = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_INTERVAL = 2'd2;

    // reset values of the registers
    localparam logic [LEN_W-1:0]   BUCKET_LENGTH_RST   = 16'd500;
    localparam logic [SLOTS_W-1:0] SLOTS_IN_USE_RST    = 5'd2;
    localparam logic [WIN_W-1:0]   WINDOW_INTERVAL_RST = 21'd1000;

    // function codes of an input item
    localparam logic FUNC_LOCATE = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_CREATED   = 3'd0,
        STAT_HIT       = 3'd1,
        STAT_RESET     = 3'd2,
        STAT_BEHIND    = 3'd3,
        STAT_REJECTED  = 3'd4,
        STAT_LIVE      = 3'd5,
        STAT_NONE_LIVE = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REJECT,
        ST_DIV,
        ST_START,
        ST_LOOK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SCAN_END
    } state_t;

endpackage

// File: hdl/swbr_in_if.sv
// ----------------------------------------------------------------------------
// swbr_in_if
// Input channel: function code and signed millisecond timestamp.
// ----------------------------------------------------------------------------
interface swbr_in_if #(
    parameter int TIME_BITS = 48
);
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic signed [TIME_BITS-1:0] time_ms;

    modport source (output valid, func, time_ms, input ready);
    modport sink   (input valid, func, time_ms, output ready);
endinterface

// File: hdl/swbr_out_if.sv
// ----------------------------------------------------------------------------
// swbr_out_if
// Result channel: status, slot, bucket start and last flag.
// ----------------------------------------------------------------------------
interface swbr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  slot_index;
    logic [46:0] bucket_begin;
    logic        last;

    modport source (output valid, status, slot_index, bucket_begin, last, input ready);
    modport sink   (input valid, status, slot_index, bucket_begin, last, output ready);
endinterface

// File: hdl/sliding_window_bucket_ring_top.sv
// ----------------------------------------------------------------------------
// Sliding-window bucket ring: locate runs the shared divide/modulo unit, which retires
// two quotient bits a cycle, then forms the bucket start and reads the addressed slot.
// Query reads and checks each slot in use in turn; one item at a time.
// Reset clears valid bits and loads register defaults at once; no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_bucket_ring_top #(
    parameter int MAX_SLOTS = 16,
    parameter int TIME_BITS = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [swbr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swbr_pkg::CFG_DATA_W-1:0] cfg_data,
    swbr_in_if.sink                       req,
    swbr_out_if.source                    rsp
);
    import swbr_pkg::*;

    localparam int DW      = TIME_BITS + (TIME_BITS % 2);
    localparam int DIV_CYC = DW / 2;
    localparam int CNT_W   = $clog2(DIV_CYC);
    localparam int CW      = $clog2(MAX_SLOTS + 1);
    localparam int IW      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    // configuration registers
    logic [LEN_W-1:0]   bl_reg;
    logic [SLOTS_W-1:0] slots_reg;
    logic [WIN_W-1:0]   wi_reg;

    // control
    state_t               state_reg, state_next;
    logic                 func_reg, func_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]        scan_reg, scan_next;
    logic [MAX_SLOTS-1:0] valid_reg, valid_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic                 out_valid_reg, out_valid_next;

    // datapath
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [DW-1:0]        div_reg, div_next;
    logic [LEN_W-1:0]     rem_reg, rem_next;
    logic [CW-1:0]        mod_reg, mod_next;
    logic [BEGIN_W-1:0]   start_reg, start_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [IW-1:0]        hold_idx_reg, hold_idx_next;
    logic [BEGIN_W-1:0]   hold_begin_reg, hold_begin_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [IDX_OUT_W-1:0] out_idx_reg, out_idx_next;
    logic [BEGIN_W-1:0]   out_begin_reg, out_begin_next;
    logic                 out_last_reg, out_last_next;

    // slot store
    logic [BEGIN_W-1:0] mem [MAX_SLOTS];
    logic [BEGIN_W-1:0] rdata_reg;
    logic [IW-1:0]      rd_addr;
    logic               mem_we;

    // shared unit results
    logic [LEN_W-1:0] bl_eff;
    logic [CW-1:0]    n_eff;
    logic [LEN_W-1:0] step_rem;
    logic [CW-1:0]    step_mod;
    logic [DW-1:0]    step_div;
    logic             out_free;
    logic             accept;
    logic [IW-1:0]    out_idx_src;
    logic [IW+IDX_OUT_W-1:0] out_idx_wide;
    logic [IW-1:0]    scan_ix;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign scan_ix  = scan_reg[IW-1:0];

    // effective bucket length and slot count
    always_comb
    begin
        bl_eff = (bl_reg == '0) ? LEN_W'(1) : bl_reg;
        if (slots_reg == '0)
            n_eff = CW'(1);
        else if (32'(slots_reg) > MAX_SLOTS)
            n_eff = CW'(MAX_SLOTS);
        else
            n_eff = CW'(slots_reg);
    end

    // shared divide unit: two restoring steps a cycle, quotient bits folded mod n
    always_comb
    begin
        logic [LEN_W:0] trial;
        logic [CW:0]    mt;
        logic           qb;
        step_rem = rem_reg;
        step_mod = mod_reg;
        step_div = div_reg;
        for (int k = 0; k < 2; k++)
        begin
            trial    = {step_rem, step_div[DW-1]};
            step_div = {step_div[DW-2:0], 1'b0};
            qb       = (trial >= {1'b0, bl_eff});
            if (qb)
                trial = trial - {1'b0, bl_eff};
            step_rem = trial[LEN_W-1:0];
            mt = {step_mod, qb};
            if (mt >= {1'b0, n_eff})
                mt = mt - {1'b0, n_eff};
            step_mod = mt[CW-1:0];
        end
    end

    // sequencer: next state and outputs
    always_comb
    begin
        logic [63:0]      t64;
        logic [63:0]      start64;
        logic [63:0]      limit64;
        logic             live;
        status_t          look_st;
        t64     = 64'(time_reg);
        start64 = t64 - 64'(rem_reg);
        limit64 = 64'(rdata_reg) + 64'(wi_reg);
        live    = valid_reg[scan_ix] && (t64 <= limit64);

        if (!valid_reg[idx_reg])
            look_st = STAT_CREATED;
        else if (rdata_reg == start_reg)
            look_st = STAT_HIT;
        else if (start_reg > rdata_reg)
            look_st = STAT_RESET;
        else
            look_st = STAT_BEHIND;

        state_next      = state_reg;
        func_next       = func_reg;
        cnt_next        = cnt_reg;
        scan_next       = scan_reg;
        valid_next      = valid_reg;
        hold_valid_next = hold_valid_reg;
        time_next       = time_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        mod_next        = mod_reg;
        start_next      = start_reg;
        idx_next        = idx_reg;
        hold_idx_next   = hold_idx_reg;
        hold_begin_next = hold_begin_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_begin_next  = out_begin_reg;
        out_last_next   = out_last_reg;
        out_idx_src     = '0;
        out_idx_next    = out_idx_reg;
        req.ready       = 1'b0;
        mem_we          = 1'b0;
        rd_addr         = (func_reg == FUNC_LOCATE) ? idx_reg : scan_ix;

        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    func_next       = req.func;
                    time_next       = req.time_ms;
                    div_next        = DW'(req.time_ms);
                    rem_next        = '0;
                    mod_next        = '0;
                    cnt_next        = '0;
                    scan_next       = '0;
                    hold_valid_next = 1'b0;
                    if (req.time_ms[TIME_BITS-1])
                        state_next = ST_REJECT;
                    else if (req.func == FUNC_LOCATE)
                        state_next = ST_DIV;
                    else
                        state_next = ST_SCAN_RD;
                end
            end

            ST_REJECT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_REJECTED;
                    out_idx_src     = '0;
                    out_begin_next  = '0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_DIV:
            begin
                div_next = step_div;
                rem_next = step_rem;
                mod_next = step_mod;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_CYC - 1))
                    state_next = ST_START;
            end

            // bucket start and slot read
            ST_START:
            begin
                start_next = start64[BEGIN_W-1:0];
                idx_next   = mod_reg[IW-1:0];
                rd_addr    = mod_reg[IW-1:0];
                state_next = ST_LOOK;
            end

            ST_LOOK:
            begin
                if (out_free)
                begin
                    if (look_st == STAT_CREATED || look_st == STAT_RESET)
                        mem_we = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    out_valid_next  = 1'b1;
                    out_status_next = look_st;
                    out_idx_src     = idx_reg;
                    out_begin_next  = start_reg;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_SCAN_RD:
            begin
                if (scan_reg == n_eff)
                    state_next = ST_SCAN_END;
                else
                    state_next = ST_SCAN_CHK;
            end

            // a live slot is held back one step so the final one can carry last
            ST_SCAN_CHK:
            begin
                if (!(live && hold_valid_reg && !out_free))
                begin
                    if (live)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = STAT_LIVE;
                            out_idx_src     = hold_idx_reg;
                            out_begin_next  = hold_begin_reg;
                            out_last_next   = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_idx_next   = scan_ix;
                        hold_begin_next = rdata_reg;
                    end
                    scan_next  = scan_reg + CW'(1);
                    state_next = ST_SCAN_RD;
                end
            end

            ST_SCAN_END:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (hold_valid_reg)
                    begin
                        out_status_next = STAT_LIVE;
                        out_idx_src     = hold_idx_reg;
                        out_begin_next  = hold_begin_reg;
                    end
                    else
                    begin
                        out_status_next = STAT_NONE_LIVE;
                        out_idx_src     = '0;
                        out_begin_next  = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // slot number on the port keeps its low four bits
        out_idx_wide = {{IDX_OUT_W{1'b0}}, out_idx_src};
        if (out_valid_next && !(out_valid_reg && !rsp.ready))
            out_idx_next = out_idx_wide[IDX_OUT_W-1:0];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bl_reg    <= BUCKET_LENGTH_RST;
            slots_reg <= SLOTS_IN_USE_RST;
            wi_reg    <= WINDOW_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BUCKET_LENGTH:   bl_reg    <= cfg_data[LEN_W-1:0];
                REG_SLOTS_IN_USE:    slots_reg <= cfg_data[SLOTS_W-1:0];
                REG_WINDOW_INTERVAL: wi_reg    <= cfg_data[WIN_W-1:0];
                default:             ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            func_reg       <= FUNC_LOCATE;
            cnt_reg        <= '0;
            scan_reg       <= '0;
            valid_reg      <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            func_reg       <= func_next;
            cnt_reg        <= cnt_next;
            scan_reg       <= scan_next;
            valid_reg      <= valid_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        time_reg       <= time_next;
        div_reg        <= div_next;
        rem_reg        <= rem_next;
        mod_reg        <= mod_next;
        start_reg      <= start_next;
        idx_reg        <= idx_next;
        hold_idx_reg   <= hold_idx_next;
        hold_begin_reg <= hold_begin_next;
        out_status_reg <= out_status_next;
        out_idx_reg    <= out_idx_next;
        out_begin_reg  <= out_begin_next;
        out_last_reg   <= out_last_next;
    end

    // slot start store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[idx_reg] <= start_reg;
        rdata_reg <= mem[rd_addr];
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.slot_index   = out_idx_reg;
    assign rsp.bucket_begin = out_begin_reg;
    assign rsp.last         = out_last_reg;

`include "sliding_window_bucket_ring_top_assert.svh"

    // every result other than a live slot closes its item
    `SWBR_ASSERT_SAME(a_single_is_last, rsp.valid && (rsp.status != STAT_LIVE), rsp.last, "non-live result without last")

    // a negative timestamp goes straight to rejection
    `SWBR_ASSERT_NEXT(a_neg_rejects, accept && req.time_ms[TIME_BITS-1], state_reg == ST_REJECT, "negative time not rejected")

    // after a locate result the addressed slot is valid
    `SWBR_ASSERT_NEXT(a_locate_marks, (state_reg == ST_LOOK) && out_free, valid_reg[idx_reg], "located slot not marked valid")

endmodule

// File: tb/sliding_window_bucket_ring_top_checker.sv
// ----------------------------------------------------------------------------
// Bucket ring result checker
// Watches the register port and both channels. It keeps its own copy of the
// ring and the registers, works out the results of every accepted item and
// compares each result item, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module sliding_window_bucket_ring_top_checker
    import swbr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    swbr_in_if                    req,
    swbr_out_if                   rsp,
    output int unsigned           fail_count,
    output int unsigned           pending,
    output int unsigned           items_seen,
    output int unsigned           results_seen
);

    localparam int RING_DEPTH = 16;
    localparam int STAMP_W    = 48;

    typedef struct packed {
        status_t              status;
        logic [IDX_OUT_W-1:0] slot;
        logic [BEGIN_W-1:0]   start;
        logic                 last;
    } bucket_result_t;

    // own copy of the ring and the registers
    logic [BEGIN_W-1:0] ring_start [RING_DEPTH];
    logic               ring_used  [RING_DEPTH];
    logic [LEN_W-1:0]   len_reg;
    logic [SLOTS_W-1:0] slots_reg;
    logic [WIN_W-1:0]   win_reg;

    bucket_result_t due_q [$];
    bucket_result_t seen_due;

    // one field of a result item against its expected value
    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // append one expected result item at the tail
    task automatic queue_due(input bucket_result_t item);
        due_q = {due_q, item};
    endtask

    // results of one item; updates the ring as the block should
    task automatic predict_ring_results(input logic fn, input logic [STAMP_W-1:0] stamp);
        longint unsigned t;
        longint unsigned len;
        longint unsigned n;
        longint unsigned idx;
        longint unsigned start;
        longint unsigned b;
        bucket_result_t  r;
        int              found;
        int              i;

        t     = stamp;
        len   = (len_reg == '0) ? 1 : len_reg;
        n     = (slots_reg == '0) ? 1 : (slots_reg > RING_DEPTH) ? RING_DEPTH : slots_reg;
        found = 0;

        if (stamp[STAMP_W-1])
        begin
            // negative time: rejected whatever the function
            r = '{status: STAT_REJECTED, slot: '0, start: '0, last: 1'b1};
            queue_due(r);
        end
        else if (fn == FUNC_LOCATE)
        begin
            idx   = (t / len) % n;
            start = t - (t % len);
            r.slot  = IDX_OUT_W'(idx);
            r.start = BEGIN_W'(start);
            r.last  = 1'b1;
            if (!ring_used[int'(idx)])
            begin
                ring_used[int'(idx)]  = 1'b1;
                ring_start[int'(idx)] = BEGIN_W'(start);
                r.status = STAT_CREATED;
            end
            else if (ring_start[int'(idx)] == BEGIN_W'(start))
            begin
                r.status = STAT_HIT;
            end
            else if (BEGIN_W'(start) > ring_start[int'(idx)])
            begin
                ring_start[int'(idx)] = BEGIN_W'(start);
                r.status = STAT_RESET;
            end
            else
            begin
                // a newer bucket is held: nothing changes
                r.status = STAT_BEHIND;
            end
            queue_due(r);
        end
        else
        begin
            // list every slot in use that is not older than the window
            for (i = 0; i < RING_DEPTH; i++)
            begin
                if (i < n && ring_used[i])
                begin
                    b = ring_start[i];
                    if (b > t || t - b <= win_reg)
                    begin
                        r = '{status: STAT_LIVE, slot: IDX_OUT_W'(i),
                              start: BEGIN_W'(b), last: 1'b0};
                        queue_due(r);
                        found++;
                    end
                end
            end
            if (found == 0)
            begin
                r = '{status: STAT_NONE_LIVE, slot: '0, start: '0, last: 1'b1};
                queue_due(r);
            end
            else
            begin
                r = due_q.pop_back();
                r.last = 1'b1;
                queue_due(r);
            end
        end
    endtask

    // register writes, result comparison, then prediction of new items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < RING_DEPTH; k++)
            begin
                ring_used[k]  = 1'b0;
                ring_start[k] = '0;
            end
            len_reg      = BUCKET_LENGTH_RST;
            slots_reg    = SLOTS_IN_USE_RST;
            win_reg      = WINDOW_INTERVAL_RST;
            due_q.delete();
            fail_count   = 0;
            items_seen   = 0;
            results_seen = 0;
            pending      = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BUCKET_LENGTH:   len_reg   = cfg_data[LEN_W-1:0];
                    REG_SLOTS_IN_USE:    slots_reg = cfg_data[SLOTS_W-1:0];
                    REG_WINDOW_INTERVAL: win_reg   = cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end

            if (rsp.valid && rsp.ready)
            begin
                results_seen++;
                if (due_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result item with none due: status %0d slot %0d start %0d last %0d",
                             $time, rsp.status, rsp.slot_index, rsp.bucket_begin, rsp.last);
                end
                else
                begin
                    seen_due = due_q.pop_front();
                    check_field("status", seen_due.status, rsp.status);
                    check_field("slot_index", seen_due.slot, rsp.slot_index);
                    check_field("bucket_begin", seen_due.start, rsp.bucket_begin);
                    check_field("last", seen_due.last, rsp.last);
                end
            end

            if (req.valid && req.ready)
            begin
                items_seen++;
                predict_ring_results(req.func, req.time_ms);
            end

            pending = due_q.size();
        end
    end

endmodule

// File: tb/sliding_window_bucket_ring_top_test.sv
// ----------------------------------------------------------------------------
// Bucket ring testbench
// Resets the block, then runs phases of register settings, each with its own
// idling pattern: a few directed locate and query items, then random items
// that follow a moving clock so that hits, resets, late arrivals and live
// listings all occur. Results are checked by the checker beside the block.
// ----------------------------------------------------------------------------
module sliding_window_bucket_ring_top_test;
    import swbr_pkg::*;

    localparam int TIME_BITS = 48;
    localparam int MAX_SLOTS = 16;
    localparam int PHASES    = 8;
    localparam int RANDOM_PER_PHASE = 19;

    localparam logic signed [TIME_BITS-1:0] T_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};
    localparam logic signed [TIME_BITS-1:0] T_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};
    localparam logic signed [TIME_BITS-1:0] T_NEG_ONE = '1;
    localparam longint STAMP_TOP = 64'h0000_7FFF_FFFF_FFFF;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned items_seen;
    int unsigned results_seen;
    int unsigned n_query    = 0;
    int unsigned n_settings = 1;

    // effective register values, for shaping the random times
    longint eff_len       = 500;
    longint eff_slots     = 2;
    longint ring_clock_ms = 0;

    swbr_in_if #(.TIME_BITS(TIME_BITS)) req ();
    swbr_out_if rsp ();

    sliding_window_bucket_ring_top #(
        .MAX_SLOTS (MAX_SLOTS),
        .TIME_BITS (TIME_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    sliding_window_bucket_ring_top_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req          (req),
        .rsp          (rsp),
        .fail_count   (fail_count),
        .pending      (pending),
        .items_seen   (items_seen),
        .results_seen (results_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard limit on the run
    initial
    begin
        #3000000;
        $display("sliding_window_bucket_ring_top test failed");
        $finish;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // 0 none, 1 sender idle, 2 receiver stalling, 3 both lightly
    task automatic set_idling(input int mode);
        case (mode)
            1:       begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 87; end
            3:       begin send_idle_pct = 17; recv_stall_pct = 17; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // all three registers, back to back
    task automatic write_settings(input logic [LEN_W-1:0] len,
                                  input logic [SLOTS_W-1:0] slots,
                                  input logic [WIN_W-1:0] win);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BUCKET_LENGTH;
        cfg_data  <= CFG_DATA_W'(len);
        @(posedge clk);
        cfg_index <= REG_SLOTS_IN_USE;
        cfg_data  <= CFG_DATA_W'(slots);
        @(posedge clk);
        cfg_index <= REG_WINDOW_INTERVAL;
        cfg_data  <= CFG_DATA_W'(win);
        @(posedge clk);
        cfg_we    <= 1'b0;
        eff_len   = (len == '0) ? 1 : len;
        eff_slots = (slots == '0) ? 1 : (slots > MAX_SLOTS) ? MAX_SLOTS : slots;
        n_settings++;
    endtask

    task automatic write_random_settings();
        logic [LEN_W-1:0]   len;
        logic [SLOTS_W-1:0] slots;
        longint             win;

        case ($urandom_range(2))
            0:       len = LEN_W'($urandom_range(1, 8));
            1:       len = LEN_W'($urandom_range(9, 2000));
            default: len = LEN_W'($urandom_range(1, 65535));
        endcase
        slots = SLOTS_W'($urandom_range(0, 31));
        win   = longint'(len) * $urandom_range(1, 20);
        if (win > 64'd2097151)
            win = 64'd2097151;
        write_settings(len, slots, WIN_W'(win));
    endtask

    // present one item and hold it until accepted
    task automatic send_item(input logic fn, input logic signed [TIME_BITS-1:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.func    <= fn;
        req.time_ms <= t;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if (fn == FUNC_QUERY)
            n_query++;
    endtask

    // mostly times around a moving clock, some jumps and negatives
    task automatic send_random_item();
        int unsigned                 pick;
        logic                        fn;
        logic [63:0]                 rnd;
        longint                      lag_ms;
        logic signed [TIME_BITS-1:0] t;

        pick = $urandom_range(99);
        fn   = ($urandom_range(99) < 30) ? FUNC_QUERY : FUNC_LOCATE;
        rnd  = {$urandom(), $urandom()};
        if (pick < 8)
        begin
            t = {1'b1, rnd[TIME_BITS-2:0]};
        end
        else if (pick < 14)
        begin
            ring_clock_ms = longint'(rnd[TIME_BITS-2:0]);
            t = TIME_BITS'(ring_clock_ms);
        end
        else
        begin
            ring_clock_ms += $urandom_range(0, 32'(eff_len));
            if (ring_clock_ms > STAMP_TOP)
                ring_clock_ms = $urandom_range(0, 1000);
            lag_ms = (pick < 35) ? $urandom_range(0, 32'(eff_len * eff_slots)) : 0;
            t = (lag_ms > ring_clock_ms) ? '0 : TIME_BITS'(ring_clock_ms - lag_ms);
        end
        send_item(fn, t);
    endtask

    // drop valid, wait for every due result, then a short settle
    task automatic drain();
        req.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= REG_BUCKET_LENGTH;
        cfg_data    <= '0;
        req.valid   <= 1'b0;
        req.func    <= FUNC_LOCATE;
        req.time_ms <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    // reset settings: length 500, two slots, window 1000
                    set_idling(0);
                    send_item(FUNC_QUERY, 0);
                    send_item(FUNC_LOCATE, T_NEG_ONE);
                    send_item(FUNC_QUERY, T_MIN);
                    send_item(FUNC_LOCATE, 0);
                    send_item(FUNC_LOCATE, 499);
                    send_item(FUNC_LOCATE, 500);
                    send_item(FUNC_LOCATE, 1000);
                    send_item(FUNC_LOCATE, 400);
                    // age exactly the window, then one past it
                    send_item(FUNC_QUERY, 1500);
                    send_item(FUNC_QUERY, 1501);
                    send_item(FUNC_QUERY, 200);
                    send_item(FUNC_QUERY, 100000);
                    send_item(FUNC_LOCATE, T_MAX);
                    send_item(FUNC_QUERY, T_MAX);
                    drain();
                end
                1:
                begin
                    // zero length and zero slots act as one
                    write_settings('0, '0, 21'd1);
                    set_idling(1);
                    send_item(FUNC_QUERY, 5);
                    send_item(FUNC_LOCATE, T_MAX);
                    send_item(FUNC_LOCATE, 3);
                    send_item(FUNC_QUERY, T_MAX);
                    drain();
                end
                2:
                begin
                    // longest buckets, slot count above the ring, widest window
                    write_settings(16'd65535, 5'd31, 21'd2097151);
                    set_idling(2);
                    send_item(FUNC_LOCATE, 983025);
                    send_item(FUNC_LOCATE, 0);
                    send_item(FUNC_QUERY, 1048560);
                    drain();
                end
                3:
                begin
                    write_settings(16'd1, 5'd16, 21'd1);
                    set_idling(3);
                end
                4:
                begin
                    // back to two slots: the others stay but are not listed
                    write_settings(16'd500, 5'd2, 21'd1000);
                    set_idling(0);
                end
                default:
                begin
                    write_random_settings();
                    set_idling(phase % 4);
                end
            endcase

            repeat (RANDOM_PER_PHASE) send_random_item();
            drain();
        end

        repeat (40) @(posedge clk);

        $display("Covered %0d items (%0d queries) and %0d results over %0d register settings,",
                 items_seen, n_query, results_seen, n_settings);
        $display("with free running, sender idle, receiver stalled and mixed idling.");
        if (fail_count == 0)
            $display("sliding_window_bucket_ring_top test passed");
        else
            $display("sliding_window_bucket_ring_top test failed");
        $finish;
    end

endmodule

// File: sliding_window_bucket_ring_top.f
+incdir+hdl
hdl/swbr_pkg.sv
hdl/swbr_in_if.sv
hdl/swbr_out_if.sv
hdl/sliding_window_bucket_ring_top.sv
tb/sliding_window_bucket_ring_top_checker.sv
tb/sliding_window_bucket_ring_top_test.sv
